>>> rtl/nnrot_pkg.sv
package nnrot_pkg;

   localparam int MAX_SIDE  = 256;
   localparam int FRAC_BITS = 14;

   localparam int SIZE_W  = 9;
   localparam int COEF_W  = 16;
   localparam int PIXEL_W = 8;
   localparam int INDEX_W = 3;

   localparam int COORD_W = SIZE_W + 1;
   localparam int PROD_W  = COORD_W + COEF_W;
   localparam int ACC_W   = PROD_W + 2;
   localparam int QUOT_W  = ACC_W - FRAC_BITS;
   localparam int SRC_W   = QUOT_W + 1;
   localparam int ADDR_W  = $clog2(MAX_SIDE * MAX_SIDE);

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'd1 << (FRAC_BITS - 1));
   localparam logic signed [ACC_W-1:0] TRUNC_BIAS = ACC_W'((64'd1 << FRAC_BITS) - 64'd1);

   typedef enum logic [INDEX_W-1:0] {
      CSR_IMAGE_HEIGHT = 3'd0,
      CSR_IMAGE_WIDTH  = 3'd1,
      CSR_CANVAS_SIDE  = 3'd2,
      CSR_COS_Q14      = 3'd3,
      CSR_SIN_Q14      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic               write;
      logic               read;
      logic [ADDR_W-1:0]  addr;
      logic [PIXEL_W-1:0] wdata;
   } store_req_type;

endpackage

>>> rtl/nnrot_store.sv
module nnrot_store
   import nnrot_pkg::*;
(
   input  logic               clock,
   input  store_req_type      req,
   output logic [PIXEL_W-1:0] rdata
);

   logic [PIXEL_W-1:0] mem [MAX_SIDE*MAX_SIDE];
   logic [PIXEL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.write) begin
         mem[req.addr] <= req.wdata;
      end
      if (req.read) begin
         rdata_ff <= mem[req.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/nearest_neighbor_image_rotate.sv
// A fetch word accepted on req_ passes through the pipeline and is offered on rsp_ from the result register.
// Throughput: one word per cycle; the six-stage pipeline holds as a whole while
// the result register is full and stalled.
// Load words write the image store in the sixth stage and give no result.
// Reset clears the pipeline valid bits and sets the registers to their defaults;
// the image store is not cleared and holds nothing defined until loaded.
module nearest_neighbor_image_rotate
   import nnrot_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic [SIZE_W-1:0]  req_row,
   input  logic [SIZE_W-1:0]  req_col,
   input  logic [PIXEL_W-1:0] req_pixel,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [PIXEL_W-1:0] rsp_value,
   output logic               rsp_inside_res,
   input  logic               csr_write,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]  csr_data
);

   typedef struct packed {
      logic               valid;
      logic               func;
      logic               load_ok;
      logic [ADDR_W-1:0]  load_addr;
      logic [PIXEL_W-1:0] pixel;
   } tag_type;

   logic [SIZE_W-1:0]        height_ff, width_ff, canvas_ff;
   logic signed [COEF_W-1:0] cos_ff, sin_ff;

   logic advance;

   tag_type tag1_in, tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff;
   logic signed [COORD_W-1:0] di_in, dj_in, di_ff, dj_ff;
   logic signed [PROD_W-1:0]  p_dc_ff, p_js_ff, p_ds_ff, p_jc_ff;
   logic signed [ACC_W-1:0]   acc_r_in, acc_c_in, acc_r_ff, acc_c_ff;
   logic signed [ACC_W-1:0]   bias_r, bias_c;
   logic signed [QUOT_W-1:0]  quot_r_in, quot_c_in, quot_r_ff, quot_c_ff;
   logic signed [SRC_W-1:0]   src_r_in, src_c_in, src_r_ff, src_c_ff;
   logic [SRC_W-2:0]          mag_r, mag_c;
   logic                      inside_in;
   logic                      rsp_valid_ff, inside_ff;
   store_req_type             store_req;
   logic [PIXEL_W-1:0]        store_rdata;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= SIZE_W'(256);
         width_ff  <= SIZE_W'(256);
         canvas_ff <= SIZE_W'(362);
         cos_ff    <= COEF_W'(16384);
         sin_ff    <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_HEIGHT: height_ff <= csr_data[SIZE_W-1:0];
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data[SIZE_W-1:0];
            CSR_CANVAS_SIDE:  canvas_ff <= csr_data[SIZE_W-1:0];
            CSR_COS_Q14:      cos_ff    <= $signed(csr_data);
            CSR_SIN_Q14:      sin_ff    <= $signed(csr_data);
            default: begin
            end
         endcase
      end
   end

   // Stage one: offsets from the canvas centre and the load address.
   always_comb begin
      tag1_in.valid     = req_valid;
      tag1_in.func      = req_func;
      tag1_in.load_ok   = (32'(req_row) < MAX_SIDE) && (32'(req_col) < MAX_SIDE);
      tag1_in.load_addr = ADDR_W'(32'(req_row) * MAX_SIDE + 32'(req_col));
      tag1_in.pixel     = req_pixel;
      di_in = $signed({1'b0, req_row}) - $signed({2'b00, canvas_ff[SIZE_W-1:1]});
      dj_in = $signed({1'b0, req_col}) - $signed({2'b00, canvas_ff[SIZE_W-1:1]});
   end

   // Stage three: rotated sums with one half added.
   assign acc_r_in = ACC_W'(p_dc_ff) - ACC_W'(p_js_ff) + ROUND_HALF;
   assign acc_c_in = ACC_W'(p_ds_ff) + ACC_W'(p_jc_ff) + ROUND_HALF;

   // Stage four: truncation toward zero.
   always_comb begin
      bias_r    = acc_r_ff + (acc_r_ff[ACC_W-1] ? TRUNC_BIAS : ACC_W'(0));
      bias_c    = acc_c_ff + (acc_c_ff[ACC_W-1] ? TRUNC_BIAS : ACC_W'(0));
      quot_r_in = $signed(bias_r[ACC_W-1:FRAC_BITS]);
      quot_c_in = $signed(bias_c[ACC_W-1:FRAC_BITS]);
   end

   // Stage five: the shift to the image centre.
   assign src_r_in = SRC_W'(quot_r_ff)
                     + $signed({{(SRC_W-SIZE_W+1){1'b0}}, height_ff[SIZE_W-1:1]});
   assign src_c_in = SRC_W'(quot_c_ff)
                     + $signed({{(SRC_W-SIZE_W+1){1'b0}}, width_ff[SIZE_W-1:1]});

   // Stage six: bounds test and the store access.
   always_comb begin
      mag_r     = src_r_ff[SRC_W-2:0];
      mag_c     = src_c_ff[SRC_W-2:0];
      inside_in = !src_r_ff[SRC_W-1] && !src_c_ff[SRC_W-1]
                  && (32'(mag_r) < 32'(height_ff)) && (32'(mag_r) < MAX_SIDE)
                  && (32'(mag_c) < 32'(width_ff))  && (32'(mag_c) < MAX_SIDE);
      store_req.write = advance && tag5_ff.valid && !tag5_ff.func && tag5_ff.load_ok;
      store_req.read  = advance && tag5_ff.valid && tag5_ff.func && inside_in;
      store_req.addr  = tag5_ff.func
                        ? ADDR_W'(32'(mag_r) * MAX_SIDE + 32'(mag_c))
                        : tag5_ff.load_addr;
      store_req.wdata = tag5_ff.pixel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         tag3_ff.valid <= 1'b0;
         tag4_ff.valid <= 1'b0;
         tag5_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         tag1_ff      <= tag1_in;
         tag2_ff      <= tag1_ff;
         tag3_ff      <= tag2_ff;
         tag4_ff      <= tag3_ff;
         tag5_ff      <= tag4_ff;
         rsp_valid_ff <= tag5_ff.valid && tag5_ff.func;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         di_ff    <= di_in;
         dj_ff    <= dj_in;
         p_dc_ff  <= PROD_W'(di_ff) * PROD_W'(cos_ff);
         p_js_ff  <= PROD_W'(dj_ff) * PROD_W'(sin_ff);
         p_ds_ff  <= PROD_W'(di_ff) * PROD_W'(sin_ff);
         p_jc_ff  <= PROD_W'(dj_ff) * PROD_W'(cos_ff);
         acc_r_ff <= acc_r_in;
         acc_c_ff <= acc_c_in;
         quot_r_ff <= quot_r_in;
         quot_c_ff <= quot_c_in;
         src_r_ff <= src_r_in;
         src_c_ff <= src_c_in;
         inside_ff <= inside_in;
      end
   end

   nnrot_store u_store (
      .clock (clock),
      .req   (store_req),
      .rdata (store_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = inside_ff;
   assign rsp_value      = inside_ff ? store_rdata : PIXEL_W'(0);

endmodule
